// File: src/ptq_pkg.sv
// Package for the paced transmit queue: codes, widths and reset constants.
// No dependencies; used by the interfaces and the top-level module under src.
`default_nettype none

package ptq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int TAG_W   = 16;
    localparam int DUR_W   = 16;
    localparam int GAP_W   = 16;
    localparam int CD_W    = 17;
    localparam int LIMIT_W = 7;
    localparam int LEVEL_W = 7;
    localparam int MODE_W  = 2;
    localparam int EV_W    = 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOWER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FASTER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_SENT = 2'd1;
    localparam logic [EV_W-1:0] EV_DROP = 2'd2;

    localparam logic [APB_ADDR_W-1:0] ADDR_QUEUE_LIMIT = 2'd0;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [GAP_W-1:0]   GAP_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

// File: src/ptq_if.sv
// Valid/ready channel interfaces for request beats and result beats.
// Depends on ptq_pkg for field widths.
`default_nettype none

interface ptq_in_if;
    logic                        valid;
    logic                        ready;
    logic [ptq_pkg::MODE_W-1:0]  mode;
    logic [ptq_pkg::TAG_W-1:0]   packet_tag;
    logic [ptq_pkg::DUR_W-1:0]   packet_duration;

    modport source (output valid, mode, packet_tag, packet_duration, input ready);
    modport sink   (input valid, mode, packet_tag, packet_duration, output ready);
endinterface

interface ptq_out_if;
    logic                         valid;
    logic                         ready;
    logic [ptq_pkg::EV_W-1:0]     event_res;
    logic [ptq_pkg::TAG_W-1:0]    sent_tag;
    logic [ptq_pkg::LEVEL_W-1:0]  queue_level;
    logic [ptq_pkg::GAP_W-1:0]    gap_now;

    modport source (output valid, event_res, sent_tag, queue_level, gap_now, input ready);
    modport sink   (input valid, event_res, sent_tag, queue_level, gap_now, output ready);
endinterface

`default_nettype wire

// File: src/ptq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ptq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/paced_transmit_queue_with_drop_unit.sv
// Top level of the paced transmit queue with tail drop and feedback pacing.
// Depends on ptq_pkg, ptq_in_if / ptq_out_if and ptq_ram.
//
//  port     dir   beat contents
//  req      in    mode, packet_tag, packet_duration
//  rsp      out   event_res, sent_tag, queue_level, gap_now
//  apb      in    queue_limit at byte address 0
//
// One beat per cycle: each request is handled in the cycle it is accepted and its
// result lands in the output register at the same edge. The packet store is a
// registered-read RAM; the next head is read ahead from the next read pointer, with
// a bypass for a write to that address. req.ready drops only while a result is held
// and rsp is stalled. Reset is immediate; no clearing pass.
`default_nettype none

module paced_transmit_queue_with_drop_unit #(
    parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ptq_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ptq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ptq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    ptq_in_if.sink                                 req,
    ptq_out_if.source                              rsp
);

    import ptq_pkg::*;

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int WORD_W = TAG_W + DUR_W;

    logic [LIMIT_W-1:0] limit_reg;

    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               sending_reg, sending_next;
    logic [CD_W-1:0]    cd_reg, cd_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;

    logic               byp_valid_reg, byp_valid_next;
    logic [WORD_W-1:0]  byp_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [EV_W-1:0]    ev_reg, ev_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [GAP_W-1:0]   gap_out_reg;

    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  head_word;
    logic [TAG_W-1:0]   head_tag;
    logic [DUR_W-1:0]   head_dur;

    logic               accept;
    logic               full;
    logic               cfg_write;
    logic [CD_W-1:0]    cd_dec;
    logic [LW-1:0]      cnt_ext;
    logic [LW-1:0]      lim_ext;

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_QUEUE_LIMIT);
    assign prdata    = (paddr == ADDR_QUEUE_LIMIT) ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // handshake
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // packet store
    assign ram_wdata = {req.packet_tag, req.packet_duration};
    assign head_word = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign head_tag  = head_word[WORD_W-1:DUR_W];
    assign head_dur  = head_word[DUR_W-1:0];

    ptq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    assign cnt_ext = LW'(count_reg);
    assign lim_ext = LW'(limit_reg);
    assign full    = (cnt_ext >= lim_ext) || (count_reg >= CW'(QUEUE_DEPTH));
    assign cd_dec  = (cd_reg != '0) ? cd_reg - 1'b1 : '0;

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        sending_next = sending_reg;
        cd_next      = cd_reg;
        gap_next     = gap_reg;
        ram_we       = 1'b0;
        ev_next      = EV_NONE;
        tag_next     = '0;

        if (accept)
        begin
            case (req.mode)
                MODE_ARRIVE:
                begin
                    if (full)
                    begin
                        ev_next  = EV_DROP;
                        tag_next = req.packet_tag;
                    end
                    else if (!sending_reg)
                    begin
                        // idle means empty: send straight through
                        ev_next      = EV_SENT;
                        tag_next     = req.packet_tag;
                        sending_next = 1'b1;
                        cd_next      = CD_W'(req.packet_duration) + CD_W'(gap_reg);
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                MODE_SLOWER:
                begin
                    if (gap_reg != GAP_MAX)
                    begin
                        gap_next = gap_reg + 1'b1;
                    end
                end
                MODE_FASTER:
                begin
                    gap_next = (gap_reg >= GAP_W'(2)) ? gap_reg - GAP_W'(2) : '0;
                end
                MODE_TICK:
                begin
                    if (sending_reg)
                    begin
                        cd_next = cd_dec;
                        if (cd_dec == '0)
                        begin
                            if (count_reg != '0)
                            begin
                                ev_next     = EV_SENT;
                                tag_next    = head_tag;
                                cd_next     = CD_W'(head_dur) + CD_W'(gap_reg);
                                rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                                   : rd_ptr_reg + 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                            else
                            begin
                                sending_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // write landing on next cycle's head address
    assign byp_valid_next = ram_we && (wr_ptr_reg == rd_ptr_next);
    assign out_valid_next = accept || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            sending_reg   <= 1'b0;
            cd_reg        <= '0;
            gap_reg       <= '0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            sending_reg   <= sending_next;
            cd_reg        <= cd_next;
            gap_reg       <= gap_next;
            byp_valid_reg <= byp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
        if (accept)
        begin
            ev_reg      <= ev_next;
            tag_reg     <= tag_next;
            level_reg   <= LEVEL_W'(count_next);
            gap_out_reg <= gap_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.event_res   = ev_reg;
    assign rsp.sent_tag    = tag_reg;
    assign rsp.queue_level = level_reg;
    assign rsp.gap_now     = gap_out_reg;

endmodule

`default_nettype wire
